// ===== rtl/ghm_pkg.sv =====
package ghm_pkg;

  localparam int TIME_BITS_DEF = 48;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_EPH_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EPV_LIMIT     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SACC_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SATS      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PDOP_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_EPH_NEAR_FRAC = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_STALE_TIMEOUT = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TIME     = 3'd7;

  // reset values
  localparam logic [15:0] EPH_LIMIT_RST     = 16'd768;
  localparam logic [15:0] EPV_LIMIT_RST     = 16'd1280;
  localparam logic [15:0] SACC_LIMIT_RST    = 16'd128;
  localparam logic [7:0]  MIN_SATS_RST      = 8'd6;
  localparam logic [15:0] PDOP_LIMIT_RST    = 16'd640;
  localparam logic [8:0]  EPH_NEAR_FRAC_RST = 9'd243;
  localparam logic [23:0] STALE_TIMEOUT_RST = 24'd1000000;
  localparam logic [23:0] HOLD_TIME_RST     = 24'd1000000;

  // decode constants
  localparam logic [3:0] FIX_NONE_MAX  = 4'd1;
  localparam logic [3:0] FIX_3D        = 4'd3;
  localparam logic [1:0] LVL_WARN      = 2'd2;
  localparam logic [1:0] LVL_CRIT      = 2'd3;
  localparam logic [3:0] MANY_WARNINGS = 4'd3;
  localparam logic [7:0] SAT_HEADROOM  = 8'd2;

  // relative report codes
  localparam logic [1:0] REL_NONE = 2'd0;
  localparam logic [1:0] REL_OK   = 2'd1;
  localparam logic [1:0] REL_LOST = 2'd2;

  // severity codes
  localparam logic [1:0] SEV_INFO = 2'd0;
  localparam logic [1:0] SEV_WARN = 2'd1;
  localparam logic [1:0] SEV_CRIT = 2'd2;

  typedef struct packed {
    logic [15:0] eph_limit;
    logic [15:0] epv_limit;
    logic [15:0] speed_acc_limit;
    logic [7:0]  min_satellites;
    logic [15:0] pdop_limit;
    logic [8:0]  eph_near_fraction;
    logic [23:0] stale_timeout_us;
    logic [23:0] hold_time_us;
    logic [31:0] pdop_sq;      // pdop_limit squared
    logic [24:0] near_thresh;  // eph_near_fraction * eph_limit
  } cfg_t;

  typedef struct packed {
    logic        gps_new;
    logic [1:0]  rel_report;
    logic        crit;
    logic        fix_fail;
    logic        sat_fail;
    logic        eph_fail;
    logic        epv_fail;
    logic        sacc_fail;
    logic        jam_det;
    logic        spoof_det;
    logic        near_eph;
    logic        near_sats;
    logic [31:0] hdop_sq;
    logic [31:0] vdop_sq;
  } check_t;

endpackage

// ===== rtl/ghm_if.sv =====
interface ghm_in_if #(
  parameter int TIME_BITS = ghm_pkg::TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 gps_new;
  logic [1:0]           rel_report;
  logic [TIME_BITS-1:0] now_us;
  logic [TIME_BITS-1:0] report_time_us;
  logic [3:0]           fix_kind;
  logic [7:0]           sats_used;
  logic [15:0]          horiz_acc;
  logic [15:0]          vert_acc;
  logic [15:0]          speed_acc;
  logic [15:0]          hdop_val;
  logic [15:0]          vdop_val;
  logic [3:0]           interference_state;

  modport source (
    output valid, gps_new, rel_report, now_us, report_time_us, fix_kind, sats_used,
           horiz_acc, vert_acc, speed_acc, hdop_val, vdop_val, interference_state,
    input  ready
  );
  modport sink (
    input  valid, gps_new, rel_report, now_us, report_time_us, fix_kind, sats_used,
           horiz_acc, vert_acc, speed_acc, hdop_val, vdop_val, interference_state,
    output ready
  );
endinterface

interface ghm_out_if;
  logic       valid;
  logic       ready;
  logic       healthy;
  logic [1:0] severity;
  logic       margin;
  logic       raw_failure;

  modport source (output valid, healthy, severity, margin, raw_failure, input ready);
  modport sink (input valid, healthy, severity, margin, raw_failure, output ready);
endinterface

interface ghm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ghm_pkg::CFG_IDX_BITS-1:0]   index;
  logic [ghm_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/gnss_health_monitor_core.sv =====
// GNSS health monitor. Each request on "report" is one evaluation of the latest
// receiver report: fix type, satellites, eph, epv, speed accuracy, PDOP (sum of
// squared HDOP/VDOP against the squared limit), jamming, spoofing, staleness
// and relative-fix loss are graded into info/warn/critical with a high/low
// margin, and the raw failure goes through a set-after-hold-time filter that
// clears at once. Every request updates the filter and relative-fix state; a
// result request is issued only for reports with gps_new set. Throughput is one
// request per clock unless a result waits; each request passes the input, check
// and result registers in turn. A stall on "result" freezes the whole pipeline,
// so report.ready drops only while a result waits. The user writes limits through
// "cfg" (always ready) only while the block is idle; the block does not enforce
// it. A zero eph/epv/speed/PDOP limit disables that check.
module gnss_health_monitor_core #(
  parameter int TIME_BITS = ghm_pkg::TIME_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  ghm_cfg_if.sink    cfg,
  ghm_in_if.sink     report,
  ghm_out_if.source  result
);

  // configuration registers
  logic [15:0] eph_limit;
  logic [15:0] epv_limit;
  logic [15:0] speed_acc_limit;
  logic [7:0]  min_satellites;
  logic [15:0] pdop_limit;
  logic [8:0]  eph_near_fraction;
  logic [23:0] stale_timeout_us;
  logic [23:0] hold_time_us;

  // products of limits, refreshed every cycle
  logic [31:0] pdop_sq;
  logic [24:0] near_thresh;

  ghm_pkg::cfg_t        cfg_bus;
  logic                 advance;
  logic                 chk_valid;
  ghm_pkg::check_t      chk;
  logic [TIME_BITS-1:0] chk_now;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eph_limit         <= ghm_pkg::EPH_LIMIT_RST;
      epv_limit         <= ghm_pkg::EPV_LIMIT_RST;
      speed_acc_limit   <= ghm_pkg::SACC_LIMIT_RST;
      min_satellites    <= ghm_pkg::MIN_SATS_RST;
      pdop_limit        <= ghm_pkg::PDOP_LIMIT_RST;
      eph_near_fraction <= ghm_pkg::EPH_NEAR_FRAC_RST;
      stale_timeout_us  <= ghm_pkg::STALE_TIMEOUT_RST;
      hold_time_us      <= ghm_pkg::HOLD_TIME_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ghm_pkg::REG_EPH_LIMIT:     eph_limit         <= cfg.data[15:0];
        ghm_pkg::REG_EPV_LIMIT:     epv_limit         <= cfg.data[15:0];
        ghm_pkg::REG_SACC_LIMIT:    speed_acc_limit   <= cfg.data[15:0];
        ghm_pkg::REG_MIN_SATS:      min_satellites    <= cfg.data[7:0];
        ghm_pkg::REG_PDOP_LIMIT:    pdop_limit        <= cfg.data[15:0];
        ghm_pkg::REG_EPH_NEAR_FRAC: eph_near_fraction <= cfg.data[8:0];
        ghm_pkg::REG_STALE_TIMEOUT: stale_timeout_us  <= cfg.data[23:0];
        ghm_pkg::REG_HOLD_TIME:     hold_time_us      <= cfg.data[23:0];
      endcase
    end
  end

  // registered, so the products follow a limit change in the next cycle
  always_ff @(posedge clk) begin
    pdop_sq     <= {16'h0000, pdop_limit} * {16'h0000, pdop_limit};
    near_thresh <= {16'h0000, eph_near_fraction} * {9'h000, eph_limit};
  end

  always_comb begin
    cfg_bus.eph_limit         = eph_limit;
    cfg_bus.epv_limit         = epv_limit;
    cfg_bus.speed_acc_limit   = speed_acc_limit;
    cfg_bus.min_satellites    = min_satellites;
    cfg_bus.pdop_limit        = pdop_limit;
    cfg_bus.eph_near_fraction = eph_near_fraction;
    cfg_bus.stale_timeout_us  = stale_timeout_us;
    cfg_bus.hold_time_us      = hold_time_us;
    cfg_bus.pdop_sq           = pdop_sq;
    cfg_bus.near_thresh       = near_thresh;
  end

  ghm_check_stage #(
    .TIME_BITS (TIME_BITS)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .cfg       (cfg_bus),
    .report    (report),
    .chk_valid (chk_valid),
    .chk       (chk),
    .chk_now   (chk_now)
  );

  ghm_grade_stage #(
    .TIME_BITS (TIME_BITS)
  ) u_grade (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_bus),
    .chk_valid (chk_valid),
    .chk       (chk),
    .chk_now   (chk_now),
    .advance   (advance),
    .result    (result)
  );

  // filtered flag clears at once, so an unhealthy result always has a raw failure
  a_unhealthy_needs_raw: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.healthy || result.raw_failure))
    else $error("unhealthy result without raw failure");

  a_raw_matches_sev: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.severity != ghm_pkg::SEV_INFO) == result.raw_failure))
    else $error("raw failure disagrees with severity");

  a_crit_low_margin: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.severity == ghm_pkg::SEV_CRIT)) |-> result.margin)
    else $error("critical result with high margin");

  // input side stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !report.ready |-> (result.valid && !result.ready))
    else $error("report stalled with no pending result");

endmodule

// ===== rtl/ghm_check_stage.sv =====
module ghm_check_stage #(
  parameter int TIME_BITS = ghm_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  ghm_pkg::cfg_t         cfg,
  ghm_in_if.sink                report,
  output logic                  chk_valid,
  output ghm_pkg::check_t       chk,
  output logic [TIME_BITS-1:0]  chk_now
);

  // input register
  logic                 s1_valid;
  logic                 s1_gps_new;
  logic [1:0]           s1_rel;
  logic [TIME_BITS-1:0] s1_now;
  logic [TIME_BITS-1:0] s1_stamp;
  logic [3:0]           s1_fix;
  logic [7:0]           s1_sats;
  logic [15:0]          s1_eph;
  logic [15:0]          s1_epv;
  logic [15:0]          s1_sacc;
  logic [15:0]          s1_hdop;
  logic [15:0]          s1_vdop;
  logic [3:0]           s1_intf;

  logic [1:0]           jam;
  logic [1:0]           spoof;
  logic [TIME_BITS-1:0] age;
  logic                 stale;
  logic [7:0]           sat_head;
  ghm_pkg::check_t      chk_next;

  assign report.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= report.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_gps_new <= report.gps_new;
      s1_rel     <= report.rel_report;
      s1_now     <= report.now_us;
      s1_stamp   <= report.report_time_us;
      s1_fix     <= report.fix_kind;
      s1_sats    <= report.sats_used;
      s1_eph     <= report.horiz_acc;
      s1_epv     <= report.vert_acc;
      s1_sacc    <= report.speed_acc;
      s1_hdop    <= report.hdop_val;
      s1_vdop    <= report.vdop_val;
      s1_intf    <= report.interference_state;
    end
  end

  always_comb begin
    jam   = s1_intf[1:0];
    spoof = s1_intf[3:2];
    // age wraps modulo 2^TIME_BITS, so a future stamp looks very old
    age   = s1_now - s1_stamp;
    stale = (s1_stamp != '0) &&
            (age > {{(TIME_BITS-24){1'b0}}, cfg.stale_timeout_us});
    // only looked at when sats >= minimum, so no wrap matters
    sat_head = s1_sats - cfg.min_satellites;

    chk_next.gps_new    = s1_gps_new;
    chk_next.rel_report = s1_rel;
    chk_next.fix_fail   = s1_fix < ghm_pkg::FIX_3D;
    chk_next.sat_fail   = s1_sats < cfg.min_satellites;
    chk_next.eph_fail   = (cfg.eph_limit != '0) && (s1_eph > cfg.eph_limit);
    chk_next.epv_fail   = (cfg.epv_limit != '0) && (s1_epv > cfg.epv_limit);
    chk_next.sacc_fail  = (cfg.speed_acc_limit != '0) && (s1_sacc > cfg.speed_acc_limit);
    chk_next.jam_det    = jam >= ghm_pkg::LVL_WARN;
    chk_next.spoof_det  = spoof >= ghm_pkg::LVL_WARN;
    chk_next.crit       = stale || (s1_fix <= ghm_pkg::FIX_NONE_MAX) ||
                          (jam == ghm_pkg::LVL_CRIT) || (spoof == ghm_pkg::LVL_CRIT) ||
                          (chk_next.eph_fail && chk_next.sat_fail);
    chk_next.near_eph   = (cfg.eph_limit != '0) &&
                          ({1'b0, s1_eph, 8'h00} > cfg.near_thresh);
    chk_next.near_sats  = (cfg.min_satellites != '0) && !chk_next.sat_fail &&
                          (sat_head <= ghm_pkg::SAT_HEADROOM);
    chk_next.hdop_sq    = {16'h0000, s1_hdop} * {16'h0000, s1_hdop};
    chk_next.vdop_sq    = {16'h0000, s1_vdop} * {16'h0000, s1_vdop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (advance) begin
      chk_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      chk     <= chk_next;
      chk_now <= s1_now;
    end
  end

endmodule

// ===== rtl/ghm_grade_stage.sv =====
module ghm_grade_stage #(
  parameter int TIME_BITS = ghm_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ghm_pkg::cfg_t         cfg,
  input  logic                  chk_valid,
  input  ghm_pkg::check_t       chk,
  input  logic [TIME_BITS-1:0]  chk_now,
  output logic                  advance,
  ghm_out_if.source             result
);

  // persistent state
  logic                 filtered_failure;
  logic                 requested_failure;
  logic [TIME_BITS-1:0] request_time_us;
  logic                 rel_seen;
  logic                 rel_fix_lost;

  // output register
  logic       out_valid;
  logic       out_healthy;
  logic [1:0] out_severity;
  logic       out_margin;
  logic       out_raw;

  logic                 rel_new;
  logic                 rel_seen_next;
  logic                 rel_fix_lost_next;
  logic                 pdop_fail;
  logic [3:0]           warn_cnt;
  logic [1:0]           sev;
  logic                 margin;
  logic                 raw;
  logic                 requested_failure_next;
  logic [TIME_BITS-1:0] request_time_us_next;
  logic [TIME_BITS-1:0] elapsed;
  logic                 filtered_failure_next;
  logic                 take;

  assign advance = !out_valid || result.ready;
  assign take    = advance && chk_valid;

  always_comb begin
    rel_new = (chk.rel_report == ghm_pkg::REL_OK) || (chk.rel_report == ghm_pkg::REL_LOST);
    rel_seen_next     = rel_new ? 1'b1 : rel_seen;
    rel_fix_lost_next = rel_new ? (chk.rel_report == ghm_pkg::REL_LOST) : rel_fix_lost;

    pdop_fail = (cfg.pdop_limit != '0) &&
                (({1'b0, chk.hdop_sq} + {1'b0, chk.vdop_sq}) > {1'b0, cfg.pdop_sq});

    warn_cnt = 4'(chk.fix_fail) + 4'(chk.sat_fail) + 4'(chk.eph_fail) +
               4'(chk.epv_fail) + 4'(chk.sacc_fail) + 4'(pdop_fail) +
               4'(chk.jam_det) + 4'(chk.spoof_det) +
               4'(rel_seen_next && rel_fix_lost_next);

    if (chk.crit) begin
      sev    = ghm_pkg::SEV_CRIT;
      margin = 1'b1;
    end else if (warn_cnt != '0) begin
      sev    = ghm_pkg::SEV_WARN;
      margin = warn_cnt >= ghm_pkg::MANY_WARNINGS;
    end else begin
      sev    = ghm_pkg::SEV_INFO;
      margin = chk.near_eph || chk.near_sats;
    end
    raw = sev != ghm_pkg::SEV_INFO;

    // set-after-hold, clear at once
    requested_failure_next = requested_failure;
    request_time_us_next   = request_time_us;
    if (raw != filtered_failure) begin
      if (raw != requested_failure) begin
        requested_failure_next = raw;
        request_time_us_next   = chk_now;
      end
    end else begin
      requested_failure_next = filtered_failure;
    end
    elapsed = chk_now - request_time_us_next;
    filtered_failure_next = filtered_failure;
    if (requested_failure_next != filtered_failure) begin
      if (filtered_failure) begin
        filtered_failure_next = 1'b0;
      end else if (elapsed >= {{(TIME_BITS-24){1'b0}}, cfg.hold_time_us}) begin
        filtered_failure_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_failure  <= 1'b0;
      requested_failure <= 1'b0;
      request_time_us   <= '0;
      rel_seen          <= 1'b0;
      rel_fix_lost      <= 1'b0;
    end else if (take) begin
      filtered_failure  <= filtered_failure_next;
      requested_failure <= requested_failure_next;
      request_time_us   <= request_time_us_next;
      rel_seen          <= rel_seen_next;
      rel_fix_lost      <= rel_fix_lost_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= chk_valid && chk.gps_new;
    end
  end

  always_ff @(posedge clk) begin
    if (take && chk.gps_new) begin
      out_healthy  <= !filtered_failure_next;
      out_severity <= sev;
      out_margin   <= margin;
      out_raw      <= raw;
    end
  end

  assign result.valid       = out_valid;
  assign result.healthy     = out_healthy;
  assign result.severity    = out_severity;
  assign result.margin      = out_margin;
  assign result.raw_failure = out_raw;

endmodule

// ===== dv/tb_gnss_health_monitor_core.sv =====
module tb_gnss_health_monitor_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_TIME_BITS    = ghm_pkg::TIME_BITS_DEF;
  localparam int RST_CYCLES      = 6;
  localparam int NUM_REGS        = 8;
  localparam int DIR_ROWS        = 26;
  localparam int N_SETTINGS      = 6;
  localparam int ITEMS_PER_SET   = 340;
  localparam int PIPE_FLUSH      = 8;     // slack after the last accepted request
  localparam int END_WAIT        = 2000;
  localparam logic [1:0] REL_UNDEF = 2'd3; // undefined relative code, reads as none

  typedef logic [TB_TIME_BITS-1:0] usec_t;

  // one evaluation request on the report channel
  typedef struct packed {
    logic       gps_new;
    logic [1:0] rel;
    usec_t      now;
    usec_t      stamp;
    logic [3:0] fix;
    logic [7:0] sats;
    logic [15:0] eph;
    logic [15:0] epv;
    logic [15:0] sacc;
    logic [15:0] hdop;
    logic [15:0] vdop;
    logic [3:0] intf;
  } report_t;

  // one health verdict on the result channel
  typedef struct packed {
    logic       healthy;
    logic [1:0] severity;
    logic       margin;
    logic       raw_failure;
  } verdict_t;

  // directed row: typed = 1 means the verdict below is the one to see
  typedef struct packed {
    report_t  rpt;
    logic     typed;
    verdict_t want;
  } dir_row_t;

  localparam verdict_t NOT_TYPED = '0;

  logic clk;
  logic rst;

  ghm_cfg_if                              cfg_bus ();
  ghm_in_if  #(.TIME_BITS(TB_TIME_BITS))  rpt_bus ();
  ghm_out_if                              res_bus ();

  gnss_health_monitor_core #(.TIME_BITS(TB_TIME_BITS)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .report (rpt_bus),
    .result (res_bus)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the limit registers and of the filter state
  // ---------------------------------------------------------------------------
  logic [15:0] lim_eph, lim_epv, lim_sacc, lim_pdop;
  logic [7:0]  lim_min_sats;
  logic [8:0]  near_frac;
  logic [23:0] stale_to, hold_to;

  logic  flt_fail;      // filtered failure flag
  logic  req_fail;      // pending request of the filter
  usec_t req_time;      // time of the pending request
  logic  rel_seen;
  logic  rel_lost;

  verdict_t    verdict_q [$];   // verdicts still owed by the block
  dir_row_t    dir_tbl [DIR_ROWS];
  logic [23:0] reg_val [NUM_REGS];
  usec_t       clock_us;        // running time base of the random reports

  int unsigned n_err, n_reports, n_results, n_info, n_warn, n_crit, n_unhealthy;
  int unsigned n_settings;
  int          stall_mode, stall_left;

  // register write, masked to the width of each limit
  function automatic void apply_reg(input logic [ghm_pkg::CFG_IDX_BITS-1:0] idx,
                                    input logic [23:0] val);
    case (idx)
      ghm_pkg::REG_EPH_LIMIT:     lim_eph      = val[15:0];
      ghm_pkg::REG_EPV_LIMIT:     lim_epv      = val[15:0];
      ghm_pkg::REG_SACC_LIMIT:    lim_sacc     = val[15:0];
      ghm_pkg::REG_MIN_SATS:      lim_min_sats = val[7:0];
      ghm_pkg::REG_PDOP_LIMIT:    lim_pdop     = val[15:0];
      ghm_pkg::REG_EPH_NEAR_FRAC: near_frac    = val[8:0];
      ghm_pkg::REG_STALE_TIMEOUT: stale_to     = val;
      ghm_pkg::REG_HOLD_TIME:     hold_to      = val;
      default: ;
    endcase
  endfunction

  // Grades one report and advances the filter; every request updates state,
  // the caller keeps the verdict only when gps_new is set.
  function automatic verdict_t grade_report(input report_t r);
    logic [1:0]  jam, spoof;
    logic        fix_f, sat_f, eph_f, epv_f, sacc_f, pdop_f, jam_f, spoof_f;
    logic        stale, rel_f, crit, raw;
    logic [32:0] dop_sq;
    usec_t       age, held;
    logic [3:0]  warn_cnt;
    verdict_t    v;
    jam   = r.intf[1:0];
    spoof = r.intf[3:2];
    if (r.rel == ghm_pkg::REL_OK || r.rel == ghm_pkg::REL_LOST) begin
      rel_seen = 1'b1;
      rel_lost = (r.rel == ghm_pkg::REL_LOST);
    end
    fix_f   = r.fix < ghm_pkg::FIX_3D;
    sat_f   = r.sats < lim_min_sats;
    eph_f   = lim_eph != 0 && r.eph > lim_eph;
    epv_f   = lim_epv != 0 && r.epv > lim_epv;
    sacc_f  = lim_sacc != 0 && r.sacc > lim_sacc;
    // PDOP without the root: hdop^2 + vdop^2 against limit^2
    dop_sq  = 33'(r.hdop) * r.hdop + 33'(r.vdop) * r.vdop;
    pdop_f  = lim_pdop != 0 && dop_sq > 33'(lim_pdop) * lim_pdop;
    jam_f   = jam >= ghm_pkg::LVL_WARN;
    spoof_f = spoof >= ghm_pkg::LVL_WARN;
    age     = r.now - r.stamp;           // wraps, a future stamp looks very old
    stale   = r.stamp != 0 && age > usec_t'(stale_to);
    rel_f   = rel_seen && rel_lost;
    crit    = stale || r.fix <= ghm_pkg::FIX_NONE_MAX || jam == ghm_pkg::LVL_CRIT ||
              spoof == ghm_pkg::LVL_CRIT || (eph_f && sat_f);
    warn_cnt = 4'(fix_f) + 4'(sat_f) + 4'(eph_f) + 4'(epv_f) + 4'(sacc_f) +
               4'(pdop_f) + 4'(jam_f) + 4'(spoof_f) + 4'(rel_f);
    v = '0;
    v.severity = ghm_pkg::SEV_INFO;
    if (crit) begin
      v.severity = ghm_pkg::SEV_CRIT;
      v.margin   = 1'b1;
    end else if (warn_cnt != 0) begin
      v.severity = ghm_pkg::SEV_WARN;
      v.margin   = warn_cnt >= ghm_pkg::MANY_WARNINGS;
    end else if (lim_eph != 0 && {r.eph, 8'd0} > 25'(near_frac) * lim_eph) begin
      v.margin = 1'b1;
    end else if (lim_min_sats != 0 && r.sats >= lim_min_sats &&
                 r.sats - lim_min_sats <= ghm_pkg::SAT_HEADROOM) begin
      v.margin = 1'b1;
    end
    raw = crit || warn_cnt != 0;
    // set after hold time, clear at once
    if (raw != flt_fail) begin
      if (raw != req_fail) begin
        req_fail = raw;
        req_time = r.now;
      end
    end else begin
      req_fail = flt_fail;
    end
    if (req_fail != flt_fail) begin
      held = r.now - req_time;
      if (flt_fail) flt_fail = 1'b0;
      else if (held >= usec_t'(hold_to)) flt_fail = 1'b1;
    end
    v.healthy     = !flt_fail;
    v.raw_failure = raw;
    return v;
  endfunction

  // value close to a limit most of the time, anywhere otherwise
  function automatic logic [15:0] near16(input logic [15:0] lim);
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return lim + 16'($urandom_range(0, 6)) - 16'd3;
      2:       return 16'($urandom_range(0, lim));
      default: return lim + 16'($urandom_range(0, 64));
    endcase
  endfunction

  function automatic logic [7:0] near8(input logic [7:0] lim);
    case ($urandom_range(0, 3))
      0:       return 8'($urandom);
      1:       return lim + 8'($urandom_range(0, 6)) - 8'd3;
      2:       return 8'($urandom_range(0, lim));
      default: return lim + 8'($urandom_range(0, 8));
    endcase
  endfunction

  // Random report on a time base that moves at the scale of the hold time,
  // so the filter sees both short glitches and persistent failures.
  function automatic report_t random_report();
    report_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)      clock_us += usec_t'($urandom_range(0, hold_to / 3 + 1));
    else if (pick < 85) clock_us += usec_t'($urandom_range(0, 1000));
    else if (pick < 95) clock_us += usec_t'(hold_to) + usec_t'($urandom_range(0, 10));
    else                clock_us += usec_t'({$urandom, $urandom});
    r.now = clock_us;
    pick = $urandom_range(0, 99);
    if (pick < 10)      r.stamp = '0;
    else if (pick < 15) r.stamp = clock_us + usec_t'($urandom_range(1, 1000));
    else if (pick < 20) r.stamp = usec_t'({$urandom, $urandom});
    else if (pick < 30) r.stamp = clock_us - usec_t'(stale_to) -
                                  usec_t'($urandom_range(0, 2)) + usec_t'(1);
    else                r.stamp = clock_us - usec_t'($urandom_range(0, stale_to));
    r.gps_new = $urandom_range(0, 7) != 0;
    r.rel     = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : ghm_pkg::REL_NONE;
    r.fix     = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(3, 8)) : 4'($urandom);
    r.sats    = near8(lim_min_sats);
    r.eph     = near16(lim_eph);
    r.epv     = near16(lim_epv);
    r.sacc    = near16(lim_sacc);
    // each axis near limit/sqrt(2)
    r.hdop    = near16(16'((32'(lim_pdop) * 181) >> 8));
    r.vdop    = near16(16'((32'(lim_pdop) * 181) >> 8));
    if ($urandom_range(0, 4) < 3)
      r.intf = {2'($urandom_range(0, 1)), 2'($urandom_range(0, 1))};
    else
      r.intf = 4'($urandom);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Report sender. valid rises with the request and stays up until the
  // handshake; the verdict is predicted at the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic send_report(input report_t r, input logic typed, input verdict_t want);
    verdict_t v;
    rpt_bus.valid              <= 1'b1;
    rpt_bus.gps_new            <= r.gps_new;
    rpt_bus.rel_report         <= r.rel;
    rpt_bus.now_us             <= r.now;
    rpt_bus.report_time_us     <= r.stamp;
    rpt_bus.fix_kind           <= r.fix;
    rpt_bus.sats_used          <= r.sats;
    rpt_bus.horiz_acc          <= r.eph;
    rpt_bus.vert_acc           <= r.epv;
    rpt_bus.speed_acc          <= r.sacc;
    rpt_bus.hdop_val           <= r.hdop;
    rpt_bus.vdop_val           <= r.vdop;
    rpt_bus.interference_state <= r.intf;
    do @(posedge clk); while (!(rpt_bus.valid && rpt_bus.ready));
    n_reports++;
    v = grade_report(r);
    if (r.gps_new) verdict_q.push_back(typed ? want : v);
  endtask

  // all owed verdicts in, then a flush wait for requests that emit nothing
  task automatic wait_idle();
    rpt_bus.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);
  endtask

  task automatic program_regs();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= ghm_pkg::CFG_IDX_BITS'(i);
      cfg_bus.data  <= reg_val[i];
      do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
      apply_reg(ghm_pkg::CFG_IDX_BITS'(i), reg_val[i]);
    end
    cfg_bus.valid <= 1'b0;
    n_settings++;
  endtask

  // limit settings: moderate, all off, all ones, wide random, short timers,
  // and the exact unit near fraction
  task automatic choose_setting(input int p);
    case (p)
      0, 5: begin
        reg_val[ghm_pkg::REG_EPH_LIMIT]     = 24'($urandom_range(100, 2000));
        reg_val[ghm_pkg::REG_EPV_LIMIT]     = 24'($urandom_range(100, 3000));
        reg_val[ghm_pkg::REG_SACC_LIMIT]    = 24'($urandom_range(20, 400));
        reg_val[ghm_pkg::REG_MIN_SATS]      = 24'($urandom_range(0, 12));
        reg_val[ghm_pkg::REG_PDOP_LIMIT]    = 24'($urandom_range(100, 1500));
        reg_val[ghm_pkg::REG_EPH_NEAR_FRAC] = (p == 5) ? 24'd256 :
                                              24'($urandom_range(200, 256));
        reg_val[ghm_pkg::REG_STALE_TIMEOUT] = 24'($urandom_range(1000, 2000000));
        reg_val[ghm_pkg::REG_HOLD_TIME]     = 24'($urandom_range(0, 2000000));
      end
      1: foreach (reg_val[i]) reg_val[i] = '0;
      2: foreach (reg_val[i]) reg_val[i] = '1;   // upper bits dropped per width
      3: foreach (reg_val[i]) reg_val[i] = 24'($urandom);
      default: begin
        reg_val[ghm_pkg::REG_EPH_LIMIT]     = 24'(ghm_pkg::EPH_LIMIT_RST);
        reg_val[ghm_pkg::REG_EPV_LIMIT]     = 24'(ghm_pkg::EPV_LIMIT_RST);
        reg_val[ghm_pkg::REG_SACC_LIMIT]    = 24'(ghm_pkg::SACC_LIMIT_RST);
        reg_val[ghm_pkg::REG_MIN_SATS]      = 24'(ghm_pkg::MIN_SATS_RST);
        reg_val[ghm_pkg::REG_PDOP_LIMIT]    = 24'(ghm_pkg::PDOP_LIMIT_RST);
        reg_val[ghm_pkg::REG_EPH_NEAR_FRAC] = 24'(ghm_pkg::EPH_NEAR_FRAC_RST);
        reg_val[ghm_pkg::REG_STALE_TIMEOUT] = 24'($urandom_range(0, 5000));
        reg_val[ghm_pkg::REG_HOLD_TIME]     = 24'($urandom_range(0, 5000));
      end
    endcase
  endtask

  // bursts of back-to-back requests with random gaps in between
  task automatic run_random(input int count);
    int sent, blen, gap;
    sent = 0;
    while (sent < count) begin
      blen = $urandom_range(1, 24);
      for (int k = 0; k < blen && sent < count; k++) begin
        send_report(random_report(), 1'b0, NOT_TYPED);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        rpt_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Result receiver: ready follows a random mode, held for a random stretch
  // (always ready, coin flip, mostly stalled).
  // ---------------------------------------------------------------------------
  initial begin
    res_bus.ready <= 1'b0;
    stall_mode = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(16, 96);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       res_bus.ready <= 1'b1;
        1:       res_bus.ready <= 1'($urandom_range(0, 1));
        default: res_bus.ready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each accepted result against the oldest owed verdict
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (verdict_q.size() == 0) begin
        $error("result request with no verdict owed");
        n_err++;
      end else begin
        want = verdict_q.pop_front();
        n_results++;
        if (res_bus.healthy !== want.healthy) begin
          $error("healthy: expected %0d, got %0d", want.healthy, res_bus.healthy);
          n_err++;
        end
        if (res_bus.severity !== want.severity) begin
          $error("severity: expected %0d, got %0d", want.severity, res_bus.severity);
          n_err++;
        end
        if (res_bus.margin !== want.margin) begin
          $error("margin: expected %0d, got %0d", want.margin, res_bus.margin);
          n_err++;
        end
        if (res_bus.raw_failure !== want.raw_failure) begin
          $error("raw_failure: expected %0d, got %0d", want.raw_failure,
                 res_bus.raw_failure);
          n_err++;
        end
        case (want.severity)
          ghm_pkg::SEV_INFO: n_info++;
          ghm_pkg::SEV_WARN: n_warn++;
          default:           n_crit++;
        endcase
        if (!want.healthy) n_unhealthy++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                        <= 1'b1;
    cfg_bus.valid              <= 1'b0;
    cfg_bus.index              <= '0;
    cfg_bus.data               <= '0;
    rpt_bus.valid              <= 1'b0;
    rpt_bus.gps_new            <= 1'b0;
    rpt_bus.rel_report         <= ghm_pkg::REL_NONE;
    rpt_bus.now_us             <= '0;
    rpt_bus.report_time_us     <= '0;
    rpt_bus.fix_kind           <= '0;
    rpt_bus.sats_used          <= '0;
    rpt_bus.horiz_acc          <= '0;
    rpt_bus.vert_acc           <= '0;
    rpt_bus.speed_acc          <= '0;
    rpt_bus.hdop_val           <= '0;
    rpt_bus.vdop_val           <= '0;
    rpt_bus.interference_state <= '0;

    // reset state of the shadow model
    lim_eph      = ghm_pkg::EPH_LIMIT_RST;
    lim_epv      = ghm_pkg::EPV_LIMIT_RST;
    lim_sacc     = ghm_pkg::SACC_LIMIT_RST;
    lim_min_sats = ghm_pkg::MIN_SATS_RST;
    lim_pdop     = ghm_pkg::PDOP_LIMIT_RST;
    near_frac    = ghm_pkg::EPH_NEAR_FRAC_RST;
    stale_to     = ghm_pkg::STALE_TIMEOUT_RST;
    hold_to      = ghm_pkg::HOLD_TIME_RST;
    flt_fail     = 1'b0;
    req_fail     = 1'b0;
    req_time     = '0;
    rel_seen     = 1'b0;
    rel_lost     = 1'b0;
    clock_us     = '0;
    n_err = 0; n_reports = 0; n_results = 0; n_settings = 0;
    n_info = 0; n_warn = 0; n_crit = 0; n_unhealthy = 0;

    // Directed rows under reset limits. Nominal report: 3D fix, 12 sats,
    // small errors, jam/spoof ok, stamped 1 ms ago.
    //   gps rel now stamp fix sats eph epv sacc hdop vdop intf | typed verdict
    dir_tbl = '{
      // nominal
      '{'{1'b1, ghm_pkg::REL_NONE, 1000000, 999000, 3, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b1, '{1'b1, ghm_pkg::SEV_INFO, 1'b0, 1'b0}},
      // no fix (0 and 1): critical, filter only requests
      '{'{1'b1, ghm_pkg::REL_NONE, 1000100, 999100, 0, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b1, '{1'b1, ghm_pkg::SEV_CRIT, 1'b1, 1'b1}},
      '{'{1'b1, ghm_pkg::REL_NONE, 1000200, 999200, 1, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b1, '{1'b1, ghm_pkg::SEV_CRIT, 1'b1, 1'b1}},
      '{'{1'b1, ghm_pkg::REL_NONE, 1000300, 999300, 3, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b1, '{1'b1, ghm_pkg::SEV_INFO, 1'b0, 1'b0}},
      // 2D fix is a single warning
      '{'{1'b1, ghm_pkg::REL_NONE, 1000400, 999400, 2, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b1, '{1'b1, ghm_pkg::SEV_WARN, 1'b0, 1'b1}},
      // fix kinds 8 and above read as 3D
      '{'{1'b1, ghm_pkg::REL_NONE, 1000500, 999500, 8, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b1, '{1'b1, ghm_pkg::SEV_INFO, 1'b0, 1'b0}},
      '{'{1'b1, ghm_pkg::REL_NONE, 1000600, 999600, 15, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b1, '{1'b1, ghm_pkg::SEV_INFO, 1'b0, 1'b0}},
      // jamming critical, then spoofing critical
      '{'{1'b1, ghm_pkg::REL_NONE, 1000700, 999700, 3, 12, 256, 256, 64, 256, 256, 4'h7},
        1'b1, '{1'b1, ghm_pkg::SEV_CRIT, 1'b1, 1'b1}},
      '{'{1'b1, ghm_pkg::REL_NONE, 1000800, 999800, 3, 12, 256, 256, 64, 256, 256, 4'hD},
        1'b1, '{1'b1, ghm_pkg::SEV_CRIT, 1'b1, 1'b1}},
      // three warnings (sats, jam, spoof) give low margin
      '{'{1'b1, ghm_pkg::REL_NONE, 1000900, 999900, 3, 5, 256, 256, 64, 256, 256, 4'hA},
        1'b1, '{1'b1, ghm_pkg::SEV_WARN, 1'b1, 1'b1}},
      // failure held exactly hold time: filtered flag sets
      '{'{1'b1, ghm_pkg::REL_NONE, 2000700, 1999700, 2, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b0, NOT_TYPED},
      // healthy again: flag clears at once
      '{'{1'b1, ghm_pkg::REL_NONE, 2000800, 1999800, 3, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b0, NOT_TYPED},
      // stale by one microsecond
      '{'{1'b1, ghm_pkg::REL_NONE, 3000000, 1999999, 3, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b1, '{1'b1, ghm_pkg::SEV_CRIT, 1'b1, 1'b1}},
      // stamp in the future wraps to a huge age
      '{'{1'b1, ghm_pkg::REL_NONE, 3000100, 3000101, 3, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b0, NOT_TYPED},
      // never stamped, and aged exactly the timeout: both fresh
      '{'{1'b1, ghm_pkg::REL_NONE, 3000200, 0, 3, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b0, NOT_TYPED},
      '{'{1'b1, ghm_pkg::REL_NONE, 3000300, 2000300, 3, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b0, NOT_TYPED},
      // eph and satellites both failing is critical
      '{'{1'b1, ghm_pkg::REL_NONE, 3000400, 2999400, 3, 5, 769, 256, 64, 256, 256, 4'h5},
        1'b0, NOT_TYPED},
      // epv, speed accuracy and PDOP over limit
      '{'{1'b1, ghm_pkg::REL_NONE, 3000500, 2999500, 3, 12, 256, 1281, 129, 640, 1, 4'h5},
        1'b0, NOT_TYPED},
      // every field at its top, undefined relative code
      '{'{1'b1, REL_UNDEF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF, 8'hFF,
          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF},
        1'b0, NOT_TYPED},
      // every field at zero, no gps report: state moves, no result
      '{'{1'b0, ghm_pkg::REL_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 4'h0},
        1'b0, NOT_TYPED},
      // relative fix lost, sticks through none and undefined codes
      '{'{1'b1, ghm_pkg::REL_LOST, 4000000, 3999000, 3, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b0, NOT_TYPED},
      '{'{1'b1, ghm_pkg::REL_NONE, 4000100, 3999100, 3, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b0, NOT_TYPED},
      '{'{1'b1, REL_UNDEF, 4000200, 3999200, 3, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b0, NOT_TYPED},
      '{'{1'b1, ghm_pkg::REL_OK, 4000300, 3999300, 3, 12, 256, 256, 64, 256, 256, 4'h5},
        1'b0, NOT_TYPED},
      // info with eph close to its limit, then sats two above minimum
      '{'{1'b1, ghm_pkg::REL_NONE, 4000400, 3999400, 3, 12, 740, 256, 64, 256, 256, 4'h5},
        1'b0, NOT_TYPED},
      '{'{1'b1, ghm_pkg::REL_NONE, 4000500, 3999500, 3, 8, 256, 256, 64, 256, 256, 4'h5},
        1'b0, NOT_TYPED}
    };

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed rows go back to back
    foreach (dir_tbl[i]) send_report(dir_tbl[i].rpt, dir_tbl[i].typed, dir_tbl[i].want);
    wait_idle();

    // random phases, each under its own limits; the sender stops until all
    // verdicts are in before every register write
    for (int p = 0; p < N_SETTINGS; p++) begin
      choose_setting(p);
      program_regs();
      case ($urandom_range(0, 2))
        0:       clock_us = usec_t'(1000000);
        1:       clock_us = '1 - usec_t'($urandom_range(0, 50000000));  // near wrap
        default: clock_us = usec_t'({$urandom, $urandom});
      endcase
      run_random(ITEMS_PER_SET);
      wait_idle();
    end

    for (int w = 0; w < END_WAIT && verdict_q.size() != 0; w++) @(posedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $error("%0d verdicts never arrived", verdict_q.size());
      n_err++;
    end

    $display("covered %0d report requests, %0d results, %0d limit settings after reset",
             n_reports, n_results, n_settings);
    $display("results by grade info/warn/crit %0d/%0d/%0d, %0d with filtered flag set",
             n_info, n_warn, n_crit, n_unhealthy);
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ghm_pkg.sv
rtl/ghm_if.sv
rtl/ghm_check_stage.sv
rtl/ghm_grade_stage.sv
rtl/gnss_health_monitor_core.sv
dv/tb_gnss_health_monitor_core.sv
